>>> src/kli_pkg.sv
// Shared types and fixed constants of the keyframe linear interpolator.
`timescale 1ns / 1ps
`default_nettype none

package kli_pkg;

    // Q16.16 times and values, Q0.16 blend fraction.
    localparam int unsigned TimeW = 32;
    localparam int unsigned ValW  = 32;
    localparam int unsigned FracW = 16;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One stored keyframe.
    typedef struct packed {
        logic        [TimeW-1:0] tkey;
        logic signed [ValW-1:0]  x;
        logic signed [ValW-1:0]  y;
        logic signed [ValW-1:0]  z;
    } t_key;

endpackage

`default_nettype wire

>>> src/kli_if.sv
// Request and result channel interfaces of the keyframe linear interpolator.
`timescale 1ns / 1ps
`default_nettype none

interface kli_in_if;
    import kli_pkg::*;

    logic                    valid;
    logic                    ready;
    t_op                     operation;
    logic        [TimeW-1:0] time_req;
    logic signed [ValW-1:0]  x_in;
    logic signed [ValW-1:0]  y_in;
    logic signed [ValW-1:0]  z_in;

    modport source (output valid, operation, time_req, x_in, y_in, z_in, input ready);
    modport sink   (input valid, operation, time_req, x_in, y_in, z_in, output ready);
endinterface

interface kli_out_if;
    import kli_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [ValW-1:0] x_out;
    logic signed [ValW-1:0] y_out;
    logic signed [ValW-1:0] z_out;
    t_status                status;

    modport source (output valid, x_out, y_out, z_out, status, input ready);
    modport sink   (input valid, x_out, y_out, z_out, status, output ready);
endinterface

`default_nettype wire

>>> src/keyframe_linear_interpolator.sv
// Top level of the keyframe linear interpolator: key table, sequencer and shared arithmetic.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps up to MAX_KEYS keyframes (time, x, y, z) sorted by time in a single-port
// write, single-port read memory, and takes one request at a time. An add request inserts
// the key after every stored key of equal time and answers with zero values and status ok,
// or with status full when the table already holds MAX_KEYS keys. A query request answers
// with status empty on an empty table, with the first key at or before the start of the
// span, with the last key at or after its end, with the earliest stored key at an exact key
// time, and otherwise with x, y and z blended linearly between the two enclosing keys. All
// values are Q16.16; the blend fraction is Q0.16. The table walk visits one memory entry at
// a time, in a read state and then a check state, because the read data is registered. An
// add moves each later stored key up one place and then writes the new key into the gap. An
// interpolating query then runs a restoring divider for the fraction and the three blends
// in turn through one shared 33 x 17 multiplier. The request side is ready whenever the
// sequencer is idle; a finished result sits in the output register and does not hold back
// the next request, and the sequencer waits only when a second result is ready before the
// first has been taken. Reset empties the table at once; no clearing pass runs, since an
// entry is read only after it has been written.
module keyframe_linear_interpolator #(
    parameter int unsigned MAX_KEYS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kli_in_if.sink    i_in,
    kli_out_if.source o_out
);
    import kli_pkg::*;

    localparam int unsigned IW    = $clog2(MAX_KEYS);
    localparam int unsigned CW    = $clog2(MAX_KEYS + 1);
    localparam int unsigned SW    = $clog2(FracW);
    localparam int unsigned ProdW = ValW + FracW + 2;

    localparam logic [1:0] LaneX = 2'd0;
    localparam logic [1:0] LaneY = 2'd1;
    localparam logic [1:0] LaneZ = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CK,
        S_ADD_PUT,
        S_Q_RD0,
        S_Q_CK0,
        S_Q_RDL,
        S_Q_CKL,
        S_Q_RDJ,
        S_Q_CKJ,
        S_DIV,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic        [CW-1:0]     r_count;
    logic        [IW-1:0]     r_idx;
    t_key                     r_new;
    t_key                     r_rdata;
    t_key                     r_prev;
    t_key                     r_cur;
    logic        [TimeW:0]    r_rem;
    logic        [TimeW-1:0]  r_den;
    logic        [FracW-1:0]  r_quo;
    logic        [SW-1:0]     r_step;
    logic        [1:0]        r_lane;
    logic signed [ProdW-1:0]  r_prod;
    logic signed [ValW-1:0]   r_res_x;
    logic signed [ValW-1:0]   r_res_y;
    logic signed [ValW-1:0]   r_res_z;
    t_status                  r_res_status;
    logic                     r_ov;
    logic signed [ValW-1:0]   r_x_out;
    logic signed [ValW-1:0]   r_y_out;
    logic signed [ValW-1:0]   r_z_out;
    t_status                  r_status_out;

    t_key                     r_mem [MAX_KEYS];

    logic                     mem_we;
    logic        [IW-1:0]     mem_waddr;
    t_key                     mem_wdata;

    logic        [TimeW:0]    rem_shift;
    logic                     div_ge;
    logic        [TimeW:0]    n_rem;
    logic signed [ValW-1:0]   lane_v0;
    logic signed [ValW-1:0]   lane_v1;
    logic signed [ValW:0]     mul_d;
    logic signed [FracW:0]    mul_f;
    logic signed [ProdW-1:0]  n_prod;
    logic signed [ValW-1:0]   acc_sum;

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_ov;
    assign o_out.x_out  = r_x_out;
    assign o_out.y_out  = r_y_out;
    assign o_out.z_out  = r_z_out;
    assign o_out.status = r_status_out;

    // One restoring division step: the low bits of the shifted dividend are all zero.
    always_comb begin
        rem_shift = {r_rem[TimeW-1:0], 1'b0};
        div_ge    = (rem_shift >= {1'b0, r_den});
        n_rem     = div_ge ? (rem_shift - {1'b0, r_den}) : rem_shift;
    end

    // Shared blend unit: one lane per multiply, product floored by the arithmetic shift.
    always_comb begin
        case (r_lane)
            LaneX: begin
                lane_v0 = r_prev.x;
                lane_v1 = r_cur.x;
            end
            LaneY: begin
                lane_v0 = r_prev.y;
                lane_v1 = r_cur.y;
            end
            default: begin
                lane_v0 = r_prev.z;
                lane_v1 = r_cur.z;
            end
        endcase
        mul_d   = {lane_v1[ValW-1], lane_v1} - {lane_v0[ValW-1], lane_v0};
        mul_f   = signed'({1'b0, r_quo});
        n_prod  = mul_d * mul_f;
        acc_sum = lane_v0 + r_prod[ValW+FracW-1:FracW];
    end

    // Table writes: an insertion moves one key up a place per step, then drops the new key in.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_new;
        case (r_state)
            S_ADD_CK: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx + IW'(1);
                mem_wdata = (r_rdata.tkey > r_new.tkey) ? r_rdata : r_new;
            end
            S_ADD_PUT: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            // The finishing state reloads the output register itself.
            if (r_ov && o_out.ready && (r_state != S_DONE)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_new.tkey   <= i_in.time_req;
                        r_new.x      <= i_in.x_in;
                        r_new.y      <= i_in.y_in;
                        r_new.z      <= i_in.z_in;
                        r_res_x      <= '0;
                        r_res_y      <= '0;
                        r_res_z      <= '0;
                        r_res_status <= ST_OK;
                        r_idx        <= '0;
                        if (i_in.operation == OP_ADD) begin
                            if (r_count == CW'(MAX_KEYS)) begin
                                r_res_status <= ST_FULL;
                                r_state      <= S_DONE;
                            end else if (r_count == '0) begin
                                r_state <= S_ADD_PUT;
                            end else begin
                                r_idx   <= IW'(r_count - CW'(1));
                                r_state <= S_ADD_RD;
                            end
                        end else begin
                            if (r_count == '0) begin
                                r_res_status <= ST_EMPTY;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_Q_RD0;
                            end
                        end
                    end
                end
                S_ADD_RD: begin
                    r_state <= S_ADD_CK;
                end
                S_ADD_CK: begin
                    // A later key moved up; an earlier or equal one means the new key is placed.
                    if (r_rdata.tkey > r_new.tkey) begin
                        if (r_idx == '0) begin
                            r_state <= S_ADD_PUT;
                        end else begin
                            r_idx   <= r_idx - IW'(1);
                            r_state <= S_ADD_RD;
                        end
                    end else begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_ADD_PUT: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_DONE;
                end
                S_Q_RD0: begin
                    r_state <= S_Q_CK0;
                end
                S_Q_CK0: begin
                    if (r_new.tkey <= r_rdata.tkey) begin
                        r_res_x <= r_rdata.x;
                        r_res_y <= r_rdata.y;
                        r_res_z <= r_rdata.z;
                        r_state <= S_DONE;
                    end else begin
                        r_prev  <= r_rdata;
                        r_idx   <= IW'(r_count - CW'(1));
                        r_state <= S_Q_RDL;
                    end
                end
                S_Q_RDL: begin
                    r_state <= S_Q_CKL;
                end
                S_Q_CKL: begin
                    if (r_new.tkey >= r_rdata.tkey) begin
                        r_res_x <= r_rdata.x;
                        r_res_y <= r_rdata.y;
                        r_res_z <= r_rdata.z;
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= IW'(1);
                        r_state <= S_Q_RDJ;
                    end
                end
                S_Q_RDJ: begin
                    r_state <= S_Q_CKJ;
                end
                S_Q_CKJ: begin
                    // The query time lies strictly inside the span, so a key at or after it exists.
                    if (r_rdata.tkey == r_new.tkey) begin
                        r_res_x <= r_rdata.x;
                        r_res_y <= r_rdata.y;
                        r_res_z <= r_rdata.z;
                        r_state <= S_DONE;
                    end else if (r_rdata.tkey > r_new.tkey) begin
                        r_cur   <= r_rdata;
                        r_rem   <= {1'b0, r_new.tkey - r_prev.tkey};
                        r_den   <= r_rdata.tkey - r_prev.tkey;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_prev  <= r_rdata;
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_Q_RDJ;
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_quo  <= {r_quo[FracW-2:0], div_ge};
                    r_step <= r_step + SW'(1);
                    if (r_step == SW'(FracW - 1)) begin
                        r_lane  <= LaneX;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= n_prod;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    case (r_lane)
                        LaneX:   r_res_x <= acc_sum;
                        LaneY:   r_res_y <= acc_sum;
                        default: r_res_z <= acc_sum;
                    endcase
                    if (r_lane == LaneZ) begin
                        r_state <= S_DONE;
                    end else begin
                        r_lane  <= r_lane + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (!r_ov || o_out.ready) begin
                        r_x_out      <= r_res_x;
                        r_y_out      <= r_res_y;
                        r_z_out      <= r_res_z;
                        r_status_out <= r_res_status;
                        r_ov         <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The table never holds more keys than it has room for.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_KEYS))
        else $error("key count above table depth");

    // Keys are only ever added, one per request.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1)))
        else $error("key count moved by more than one");

    // A dropped add is reported only while the table is full.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_FULL)) |-> (r_count == CW'(MAX_KEYS)))
        else $error("full status with room in the table");

    // The partial remainder stays below the divisor, so the fraction fits in Q0.16.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {1'b0, r_den}))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

>>> test/tb_keyframe_linear_interpolator.sv
// Self-checking testbench for the keyframe linear interpolator with randomized handshakes.
`timescale 1ns / 1ps

module tb_keyframe_linear_interpolator;
    import kli_pkg::*;

    localparam int unsigned KEY_CAP         = 16;
    localparam int unsigned RANDOM_REQUESTS = 730;
    // The drain waits well past the slowest request.
    localparam int unsigned DRAIN_CYCLES    = 100;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    // One request as the sender offers it.
    typedef struct {
        t_op                    op;
        logic [TimeW-1:0]       tq;
        logic signed [ValW-1:0] x;
        logic signed [ValW-1:0] y;
        logic signed [ValW-1:0] z;
    } t_request;

    // One result as the block should return it.
    typedef struct {
        logic signed [ValW-1:0] x;
        logic signed [ValW-1:0] y;
        logic signed [ValW-1:0] z;
        t_status                status;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    kli_in_if  req_ch ();
    kli_out_if res_ch ();

    keyframe_linear_interpolator #(
        .MAX_KEYS (KEY_CAP)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    // Requests still to be offered, and results still owed by the block.
    t_request queued_requests[$];
    t_answer  owed_answers[$];

    // Our own copy of the keyframe table, kept in step with every accepted request.
    logic [TimeW-1:0]       tab_t[KEY_CAP];
    logic signed [ValW-1:0] tab_x[KEY_CAP];
    logic signed [ValW-1:0] tab_y[KEY_CAP];
    logic signed [ValW-1:0] tab_z[KEY_CAP];
    int unsigned            tab_count = 0;

    // Times of the first KEY_CAP keys the stimulus queues for adding, used to aim queries at real segments.
    logic [TimeW-1:0] planned_times[$];

    t_request    offered_req;
    t_answer     owed;
    int unsigned requests_total = 0;
    int unsigned requests_taken = 0;
    int unsigned answers_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned send_wait      = 0;
    int unsigned recv_wait      = 0;
    int unsigned cycle_count    = 0;
    logic        hold_results;

    always #2 i_clk = ~i_clk;

    // Linear blend of one value: v0 + floor(frac * (v1 - v0) / 65536).
    // The product needs 49 bits; an arithmetic shift on a 64-bit signed value floors.
    function automatic logic signed [ValW-1:0] blend_value(
        logic signed [ValW-1:0] v0,
        logic signed [ValW-1:0] v1,
        logic [FracW-1:0]       frac
    );
        longint a;
        longint b;
        longint f;
        longint prod;
        a = v0;
        b = v1;
        f = frac;
        prod = (b - a) * f;
        return ValW'(a + (prod >>> 16));
    endfunction

    // Applies one request to the table copy and returns the result it must produce.
    function automatic t_answer key_table_response(t_request req);
        t_answer          ans;
        int unsigned      pos;
        int unsigned      i;
        int unsigned      last;
        bit               found;
        logic [63:0]      num;
        logic [63:0]      den;
        logic [FracW-1:0] frac;

        ans.x      = '0;
        ans.y      = '0;
        ans.z      = '0;
        ans.status = ST_OK;

        if (req.op == OP_ADD) begin
            if (tab_count >= KEY_CAP) begin
                ans.status = ST_FULL;
                return ans;
            end
            // Insert after every key whose time is equal or lower.
            pos = 0;
            while (pos < tab_count && tab_t[pos] <= req.tq) pos++;
            for (i = tab_count; i > pos; i--) begin
                tab_t[i] = tab_t[i-1];
                tab_x[i] = tab_x[i-1];
                tab_y[i] = tab_y[i-1];
                tab_z[i] = tab_z[i-1];
            end
            tab_t[pos] = req.tq;
            tab_x[pos] = req.x;
            tab_y[pos] = req.y;
            tab_z[pos] = req.z;
            tab_count++;
            return ans;
        end

        if (tab_count == 0) begin
            ans.status = ST_EMPTY;
            return ans;
        end

        last = tab_count - 1;
        pos  = 0;
        found = 1'b0;
        if (req.tq <= tab_t[0]) begin
            pos = 0;
        end else if (req.tq >= tab_t[last]) begin
            pos = last;
        end else begin
            for (i = 0; i < last && !found; i++) begin
                if (req.tq >= tab_t[i] && req.tq <= tab_t[i+1]) begin
                    found = 1'b1;
                    if (req.tq == tab_t[i]) begin
                        pos = i;
                    end else if (req.tq == tab_t[i+1]) begin
                        pos = i + 1;
                    end else begin
                        num  = {32'd0, req.tq - tab_t[i]} << 16;
                        den  = {32'd0, tab_t[i+1] - tab_t[i]};
                        frac = FracW'(num / den);
                        ans.x = blend_value(tab_x[i], tab_x[i+1], frac);
                        ans.y = blend_value(tab_y[i], tab_y[i+1], frac);
                        ans.z = blend_value(tab_z[i], tab_z[i+1], frac);
                        return ans;
                    end
                end
            end
        end
        ans.x = tab_x[pos];
        ans.y = tab_y[pos];
        ans.z = tab_z[pos];
        return ans;
    endfunction

    // Random wait before the next request or result, with calm stretches of 60 transfers
    // in every 180 in which the waiting side does not idle.
    function automatic int unsigned draw_wait(int unsigned seq);
        if ((seq / 60) % 3 == 1) return 0;
        return $urandom_range(0, 15);
    endfunction

    function automatic logic signed [ValW-1:0] random_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            3: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_request(t_op op, logic [TimeW-1:0] tq,
                                logic signed [ValW-1:0] x,
                                logic signed [ValW-1:0] y,
                                logic signed [ValW-1:0] z);
        t_request req;
        req.op = op;
        req.tq = tq;
        req.x  = x;
        req.y  = y;
        req.z  = z;
        queued_requests.push_back(req);
        if (op == OP_ADD && planned_times.size() < KEY_CAP) planned_times.push_back(tq);
    endtask

    // Query times aimed at stored keys, their neighbors, the span between two keys, the ends of the range or anywhere.
    function automatic logic [TimeW-1:0] aimed_time();
        logic [TimeW-1:0] a;
        logic [TimeW-1:0] b;
        logic [63:0]      width;
        if (planned_times.size() == 0) return $urandom;
        a = planned_times[$urandom_range(0, planned_times.size() - 1)];
        b = planned_times[$urandom_range(0, planned_times.size() - 1)];
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return a;
            2: return a + 1;
            3: return a - 1;
            4: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default: begin
                if (a > b) begin
                    width = {32'd0, a - b} + 64'd1;
                    return b + TimeW'({$urandom, $urandom} % width);
                end
                width = {32'd0, b - a} + 64'd1;
                return a + TimeW'({$urandom, $urandom} % width);
            end
        endcase
    endfunction

    // Request driver: offers the queued requests one after another and records the
    // result owed for each request at the edge where it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                owed_answers.push_back(key_table_response(offered_req));
                requests_taken++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    req_ch.valid <= 1'b0;
                end else if (queued_requests.size() > 0) begin
                    offered_req = queued_requests.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.operation <= offered_req.op;
                    req_ch.time_req  <= offered_req.tq;
                    req_ch.x_in      <= offered_req.x;
                    req_ch.y_in      <= offered_req.y;
                    req_ch.z_in      <= offered_req.z;
                    send_wait = draw_wait(requests_taken);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks every taken result against the oldest owed one and
    // stalls at random between results, or for a long stretch while held.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                answers_seen++;
                if (owed_answers.size() == 0) begin
                    $error("result with none owed: x_out=%0d y_out=%0d z_out=%0d status=%0d",
                           res_ch.x_out, res_ch.y_out, res_ch.z_out, res_ch.status);
                    mismatches++;
                end else begin
                    owed = owed_answers.pop_front();
                    if (res_ch.x_out !== owed.x) begin
                        $error("x_out: expected %0d, got %0d", owed.x, res_ch.x_out);
                        mismatches++;
                    end
                    if (res_ch.y_out !== owed.y) begin
                        $error("y_out: expected %0d, got %0d", owed.y, res_ch.y_out);
                        mismatches++;
                    end
                    if (res_ch.z_out !== owed.z) begin
                        $error("z_out: expected %0d, got %0d", owed.z, res_ch.z_out);
                        mismatches++;
                    end
                    if (res_ch.status !== owed.status) begin
                        $error("status: expected %0d, got %0d", owed.status, res_ch.status);
                        mismatches++;
                    end
                end
                recv_wait = draw_wait(answers_seen + 30);
            end
            if (hold_results) begin
                res_ch.ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Long result hold-off in the middle of the random part, so that the block
    // fills its output register, stalls and pushes back on the request side.
    initial begin
        hold_results = 1'b0;
        wait (requests_taken >= 300);
        @(posedge i_clk);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_results <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("keyframe_linear_interpolator: mismatch");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        logic [TimeW-1:0] tq;

        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_ADD;
        req_ch.time_req  = '0;
        req_ch.x_in      = '0;
        req_ch.y_in      = '0;
        req_ch.z_in      = '0;
        res_ch.ready     = 1'b0;

        // Directed part. Queries on the empty table come first.
        push_request(OP_QUERY, 32'h0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1);
        push_request(OP_QUERY, 32'hFFFF_FFFF, 32'sh0, 32'sh0, 32'sh0);
        // A single key: every query clamps to it.
        push_request(OP_ADD, 32'h0001_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678);
        push_request(OP_QUERY, 32'h0000_0000, random_value(), random_value(), random_value());
        push_request(OP_QUERY, 32'h0001_0000, random_value(), random_value(), random_value());
        push_request(OP_QUERY, 32'hFFFF_FFFF, random_value(), random_value(), random_value());
        // Second key with x and y at the opposite extremes, so the blend spans the widest range.
        push_request(OP_ADD, 32'h0003_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1);
        push_request(OP_QUERY, 32'h0002_0000, random_value(), random_value(), random_value());
        push_request(OP_QUERY, 32'h0001_0001, random_value(), random_value(), random_value());
        push_request(OP_QUERY, 32'h0002_FFFF, random_value(), random_value(), random_value());
        // A duplicate time at the end of the span: the latest one added is returned.
        push_request(OP_ADD, 32'h0003_0000, 32'sd1, 32'sd2, 32'sd3);
        push_request(OP_QUERY, 32'h0003_0000, random_value(), random_value(), random_value());
        // Once a key follows, the same time lies inside the span and the earliest key wins.
        push_request(OP_ADD, 32'hFFFF_FFFF, 32'sh0, 32'sh0, 32'sh0);
        push_request(OP_QUERY, 32'h0003_0000, random_value(), random_value(), random_value());
        push_request(OP_QUERY, 32'h8000_0000, random_value(), random_value(), random_value());
        push_request(OP_QUERY, 32'hFFFF_FFFE, random_value(), random_value(), random_value());
        // A key at time zero: queries at the start of the span, between it and the next key, and at that key.
        push_request(OP_ADD, 32'h0000_0000, -32'sd65536, 32'sh7FFF_FFFF, 32'sh8000_0000);
        push_request(OP_QUERY, 32'h0000_0000, random_value(), random_value(), random_value());
        push_request(OP_QUERY, 32'h0000_8000, random_value(), random_value(), random_value());
        push_request(OP_QUERY, 32'h0001_0000, random_value(), random_value(), random_value());

        // Random part: adds fill the table with random keys and then bounce off it as
        // full; most requests are queries aimed at the keys and the segments between.
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if ($urandom_range(0, 99) < 15) begin
                case ($urandom_range(0, 3))
                    0: tq = $urandom;
                    1: tq = $urandom_range(0, 32'h000F_FFFF);
                    2: tq = planned_times[$urandom_range(0, planned_times.size() - 1)];
                    default: tq = aimed_time();
                endcase
                push_request(OP_ADD, tq, random_value(), random_value(), random_value());
            end else begin
                push_request(OP_QUERY, aimed_time(), $urandom, $urandom, $urandom);
            end
        end
        requests_total = queued_requests.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_taken < requests_total || owed_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("keyframe_linear_interpolator: match");
        end else begin
            $display("keyframe_linear_interpolator: mismatch");
        end
        $finish;
    end

endmodule
